// ----- design/gamepad_autorepeat_defines.svh -----
// ---------------------------------------------------------------------------
// Gamepad auto-repeat assertion macros
// Shared property wrappers, clocked on clk and disabled while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef GAMEPAD_AUTOREPEAT_DEFINES_SVH
`define GAMEPAD_AUTOREPEAT_DEFINES_SVH

// same-cycle implication
`define GPAR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define GPAR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/gpar_pkg.sv -----
// ---------------------------------------------------------------------------
// Gamepad auto-repeat package
// Field widths, register codes, reset values and the lane control struct.
// ---------------------------------------------------------------------------
`default_nettype none

package gpar_pkg;

  localparam int LANES   = 16;
  localparam int CNT_W   = 9;
  localparam int DELAY_W = 8;
  localparam int THR_W   = 15;
  localparam int STICK_W = 16;
  localparam int PL_W    = 2;
  localparam int CFG_W   = 15;

  localparam logic [1:0] CFG_DELAY  = 2'd0;
  localparam logic [1:0] CFG_PERIOD = 2'd1;
  localparam logic [1:0] CFG_THRESH = 2'd2;

  localparam logic [DELAY_W-1:0] DELAY_RST  = 8'd30;
  localparam logic [DELAY_W-1:0] PERIOD_RST = 8'd6;
  localparam logic [THR_W-1:0]   THRESH_RST = 15'd16384;

  localparam int BIT_UP    = 0;
  localparam int BIT_DOWN  = 1;
  localparam int BIT_LEFT  = 2;
  localparam int BIT_RIGHT = 3;

  typedef struct packed {
    logic               upd;
    logic [DELAY_W-1:0] delay;
    logic [CNT_W-1:0]   limit;
  } gpar_lane_ctl_t;

endpackage

`default_nettype wire

// ----- design/gamepad_autorepeat.sv -----
// ---------------------------------------------------------------------------
// Gamepad auto-repeat
// Per-player button conditioning with stick folding and typematic repeat.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one frame for one player:
//   player, 16 raw button bits and the signed left stick.
//   Result channel (out_valid/out_ready) returns exactly one result per
//   frame, in order: player echo, held, repeat and newly pressed bits.
//   Each cfg write sets delay, period or threshold by cfg_index; write
//   it only while the block is idle.
//   A frame passes the input register, then the result register, where it
//   waits for out_ready. Throughput: one frame per cycle while out_ready
//   stays high; all sixteen button lanes evaluate in parallel in the
//   single compute stage between the two registers.
//   Reset clears hold counters, last-frame bits and both valid flags, and
//   loads the register defaults.
//   When the receiver stalls, the result register holds, one more frame
//   waits in the input register, then in_ready drops.
// ---------------------------------------------------------------------------
`default_nettype none
`include "gamepad_autorepeat_defines.svh"

module gamepad_autorepeat #(
  parameter int PLAYERS = 4,
  parameter int BUTTONS = 16
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [gpar_pkg::PL_W-1:0]    in_player,
  input  wire logic [gpar_pkg::LANES-1:0]   in_buttons,
  input  wire logic [gpar_pkg::STICK_W-1:0] in_left_x,
  input  wire logic [gpar_pkg::STICK_W-1:0] in_left_y,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic      [gpar_pkg::PL_W-1:0]    out_player,
  output logic      [gpar_pkg::LANES-1:0]   out_held_buttons,
  output logic      [gpar_pkg::LANES-1:0]   out_repeat_buttons,
  output logic      [gpar_pkg::LANES-1:0]   out_pressed_edges,
  input  wire logic                         cfg_we,
  input  wire logic [1:0]                   cfg_index,
  input  wire logic [gpar_pkg::CFG_W-1:0]   cfg_data
);
  import gpar_pkg::*;

  localparam int SLOT_W = (PLAYERS > 1) ? $clog2(PLAYERS) : 1;

  logic [DELAY_W-1:0] delay_r;
  logic [DELAY_W-1:0] period_r;
  logic [THR_W-1:0]   thresh_r;

  logic               s1_valid_r;
  logic [PL_W-1:0]    s1_player_r;
  logic [LANES-1:0]   s1_buttons_r;
  logic [STICK_W-1:0] s1_x_r;
  logic [STICK_W-1:0] s1_y_r;

  logic [3:0]         slot_acc;
  logic [SLOT_W-1:0]  slot;
  logic [LANES-1:0]   held;
  logic [LANES-1:0]   prev;
  logic [LANES-1:0]   rep;
  logic               advance;
  gpar_lane_ctl_t     ctl;

  logic               stall_s1;
  logic               rep_stray;
  logic               edge_stray;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delay_r  <= DELAY_RST;
      period_r <= PERIOD_RST;
      thresh_r <= THRESH_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_DELAY:  delay_r  <= cfg_data[DELAY_W-1:0];
        CFG_PERIOD: period_r <= cfg_data[DELAY_W-1:0];
        CFG_THRESH: thresh_r <= cfg_data[THR_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_ready = !s1_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_player_r  <= in_player;
      s1_buttons_r <= in_buttons;
      s1_x_r       <= in_left_x;
      s1_y_r       <= in_left_y;
    end
  end

  // wrap the player field onto the state slots
  always_comb begin
    slot_acc = 4'(s1_player_r);
    for (int k = 0; k < 3; k++) begin
      if (slot_acc >= 4'(PLAYERS)) begin
        slot_acc = slot_acc - 4'(PLAYERS);
      end
    end
  end

  assign slot      = SLOT_W'(slot_acc);
  assign ctl.upd   = advance;
  assign ctl.delay = delay_r;
  assign ctl.limit = {1'b0, delay_r} + {1'b0, period_r};

  gpar_fold #(
    .BUTTONS(BUTTONS)
  ) u_fold (
    .buttons  (s1_buttons_r),
    .left_x   (s1_x_r),
    .left_y   (s1_y_r),
    .threshold(thresh_r),
    .held     (held)
  );

  for (genvar i = 0; i < LANES; i++) begin : g_lane
    gpar_lane #(
      .PLAYERS(PLAYERS)
    ) u_lane (
      .clk  (clk),
      .rst_n(rst_n),
      .ctl  (ctl),
      .slot (slot),
      .held (held[i]),
      .prev (prev[i]),
      .rep  (rep[i])
    );
  end

  gpar_merge #(
    .PLAYERS(PLAYERS)
  ) u_merge (
    .clk               (clk),
    .rst_n             (rst_n),
    .s1_valid          (s1_valid_r),
    .player            (s1_player_r),
    .slot              (slot),
    .held              (held),
    .rep               (rep),
    .out_ready         (out_ready),
    .advance           (advance),
    .prev              (prev),
    .out_valid         (out_valid),
    .out_player        (out_player),
    .out_held_buttons  (out_held_buttons),
    .out_repeat_buttons(out_repeat_buttons),
    .out_pressed_edges (out_pressed_edges)
  );

  assign stall_s1   = s1_valid_r && out_valid && !out_ready;
  assign rep_stray  = |(out_repeat_buttons & ~out_held_buttons);
  assign edge_stray = |(out_pressed_edges & ~out_held_buttons);

  `GPAR_ASSERT_NEXT(a_advance_fills, advance, out_valid, "advance left no result")
  `GPAR_ASSERT_NEXT(a_stall_holds_s1, stall_s1, s1_valid_r, "frame lost under stall")
  `GPAR_ASSERT_NOW(a_rep_in_held, out_valid, !rep_stray, "repeat on released button")
  `GPAR_ASSERT_NOW(a_edge_in_held, out_valid, !edge_stray, "edge on released button")

endmodule

`default_nettype wire

// ----- design/gpar_fold.sv -----
// ---------------------------------------------------------------------------
// Gamepad auto-repeat stick fold
// Folds the left stick into the direction bits and masks unused buttons.
// ---------------------------------------------------------------------------
`default_nettype none

module gpar_fold #(
  parameter int BUTTONS = 16
) (
  input  wire logic [gpar_pkg::LANES-1:0]   buttons,
  input  wire logic [gpar_pkg::STICK_W-1:0] left_x,
  input  wire logic [gpar_pkg::STICK_W-1:0] left_y,
  input  wire logic [gpar_pkg::THR_W-1:0]   threshold,
  output logic      [gpar_pkg::LANES-1:0]   held
);
  import gpar_pkg::*;

  logic signed [STICK_W:0] x_e;
  logic signed [STICK_W:0] y_e;
  logic signed [STICK_W:0] t_e;
  logic signed [STICK_W:0] nt_e;
  logic [LANES-1:0]        mask;
  logic [LANES-1:0]        raw;

  assign x_e  = {left_x[STICK_W-1], left_x};
  assign y_e  = {left_y[STICK_W-1], left_y};
  assign t_e  = {2'b00, threshold};
  assign nt_e = -t_e;

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      mask[i] = (i < BUTTONS);
    end
  end

  always_comb begin
    raw = buttons;
    if (x_e >= t_e) begin
      raw[BIT_RIGHT] = 1'b1;
    end else if (x_e <= nt_e) begin
      raw[BIT_LEFT] = 1'b1;
    end
    if (y_e >= t_e) begin
      raw[BIT_UP] = 1'b1;
    end else if (y_e <= nt_e) begin
      raw[BIT_DOWN] = 1'b1;
    end
    held = raw & mask;
  end

endmodule

`default_nettype wire

// ----- design/gpar_lane.sv -----
// ---------------------------------------------------------------------------
// Gamepad auto-repeat lane
// Hold counter of one button for every player, and its repeat pulse.
// ---------------------------------------------------------------------------
`default_nettype none

module gpar_lane #(
  parameter int PLAYERS = 4,
  localparam int SLOT_W = (PLAYERS > 1) ? $clog2(PLAYERS) : 1
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire gpar_pkg::gpar_lane_ctl_t ctl,
  input  wire logic [SLOT_W-1:0]       slot,
  input  wire logic                    held,
  input  wire logic                    prev,
  output logic                         rep
);
  import gpar_pkg::*;

  logic [CNT_W-1:0] cnt_r [PLAYERS];
  logic [CNT_W-1:0] cnt_nxt;
  logic [CNT_W-1:0] cur;

  assign cur = cnt_r[slot];

  always_comb begin
    cnt_nxt = '0;
    rep     = 1'b0;
    if (held) begin
      rep = 1'b1;
      if (prev) begin
        if (cur == '0) begin
          cnt_nxt = CNT_W'(1);
        end else if (cur >= ctl.limit) begin
          cnt_nxt = CNT_W'({1'b0, ctl.delay} + 9'd1);
        end else begin
          rep     = 1'b0;
          cnt_nxt = cur + CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int p = 0; p < PLAYERS; p++) begin
        cnt_r[p] <= '0;
      end
    end else if (ctl.upd) begin
      cnt_r[slot] <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- design/gpar_merge.sv -----
// ---------------------------------------------------------------------------
// Gamepad auto-repeat merge stage
// Gathers lane pulses, tracks last frame per player, holds the result.
// ---------------------------------------------------------------------------
`default_nettype none

module gpar_merge #(
  parameter int PLAYERS = 4,
  localparam int SLOT_W = (PLAYERS > 1) ? $clog2(PLAYERS) : 1
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         s1_valid,
  input  wire logic [gpar_pkg::PL_W-1:0]    player,
  input  wire logic [SLOT_W-1:0]            slot,
  input  wire logic [gpar_pkg::LANES-1:0]   held,
  input  wire logic [gpar_pkg::LANES-1:0]   rep,
  input  wire logic                         out_ready,
  output logic                              advance,
  output logic      [gpar_pkg::LANES-1:0]   prev,
  output logic                              out_valid,
  output logic      [gpar_pkg::PL_W-1:0]    out_player,
  output logic      [gpar_pkg::LANES-1:0]   out_held_buttons,
  output logic      [gpar_pkg::LANES-1:0]   out_repeat_buttons,
  output logic      [gpar_pkg::LANES-1:0]   out_pressed_edges
);
  import gpar_pkg::*;

  logic [LANES-1:0] last_r [PLAYERS];
  logic             out_valid_r;
  logic [PL_W-1:0]  player_r;
  logic [LANES-1:0] held_r;
  logic [LANES-1:0] rep_r;
  logic [LANES-1:0] edge_r;

  assign prev    = last_r[slot];
  assign advance = s1_valid && (!out_valid_r || out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      for (int p = 0; p < PLAYERS; p++) begin
        last_r[p] <= '0;
      end
    end else begin
      if (advance) begin
        out_valid_r  <= 1'b1;
        last_r[slot] <= held;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      player_r <= player;
      held_r   <= held;
      rep_r    <= rep;
      edge_r   <= held & ~prev;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_player         = player_r;
  assign out_held_buttons   = held_r;
  assign out_repeat_buttons = rep_r;
  assign out_pressed_edges  = edge_r;

endmodule

`default_nettype wire

// ----- tb/gamepad_repeat_checker.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Gamepad auto-repeat checker
// Watches the frame, result and register ports, predicts each frame's
// folded, repeated and newly pressed bits, and compares results in order.
// ---------------------------------------------------------------------------
module gamepad_repeat_checker (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  logic                         in_ready,
  input  logic [gpar_pkg::PL_W-1:0]    in_player,
  input  logic [gpar_pkg::LANES-1:0]   in_buttons,
  input  logic [gpar_pkg::STICK_W-1:0] in_left_x,
  input  logic [gpar_pkg::STICK_W-1:0] in_left_y,
  input  logic                         out_valid,
  input  logic                         out_ready,
  input  logic [gpar_pkg::PL_W-1:0]    out_player,
  input  logic [gpar_pkg::LANES-1:0]   out_held_buttons,
  input  logic [gpar_pkg::LANES-1:0]   out_repeat_buttons,
  input  logic [gpar_pkg::LANES-1:0]   out_pressed_edges,
  input  logic                         cfg_we,
  input  logic [1:0]                   cfg_index,
  input  logic [gpar_pkg::CFG_W-1:0]   cfg_data,
  output int                           mismatches,
  output int                           due_count,
  output int                           results_seen,
  output int                           pulses_seen
);
  import gpar_pkg::*;

  typedef struct packed {
    logic [PL_W-1:0]  player;
    logic [LANES-1:0] held;
    logic [LANES-1:0] rep;
    logic [LANES-1:0] edges;
  } frame_result_t;

  localparam int NUM_PLAYERS = 4;

  logic [DELAY_W-1:0] delay_q;
  logic [DELAY_W-1:0] period_q;
  logic [THR_W-1:0]   thresh_q;
  logic [LANES-1:0]   last_held [NUM_PLAYERS];
  logic [CNT_W-1:0]   hold_cnt  [NUM_PLAYERS][LANES];
  frame_result_t      due_results[$];
  int                 err_count;
  int                 result_total;
  int                 pulse_total;

  task automatic report(input string field, input logic [LANES-1:0] got,
                        input logic [LANES-1:0] want);
    $display("%0t mismatch on %s: got %h, want %h (result %0d)",
             $time, field, got, want, result_total);
    err_count++;
  endtask

  task automatic fold_and_repeat(input logic [PL_W-1:0] pl, input logic [LANES-1:0] raw,
                                 input logic [STICK_W-1:0] sx, input logic [STICK_W-1:0] sy,
                                 output frame_result_t r);
    int               x;
    int               y;
    int               t;
    logic [LANES-1:0] held;
    logic [LANES-1:0] prev;
    logic [LANES-1:0] rep;
    logic [CNT_W-1:0] limit;
    logic [CNT_W-1:0] c;
    x = $signed(sx);
    y = $signed(sy);
    t = int'(thresh_q);
    held = raw;
    prev = last_held[pl];
    if (x >= t) held[BIT_RIGHT] = 1'b1;
    else if (x <= -t) held[BIT_LEFT] = 1'b1;
    if (y >= t) held[BIT_UP] = 1'b1;
    else if (y <= -t) held[BIT_DOWN] = 1'b1;
    limit = {1'b0, delay_q} + {1'b0, period_q};
    rep = held;
    for (int b = 0; b < LANES; b++) begin
      c = hold_cnt[pl][b];
      if (!held[b] || !prev[b]) begin
        c = '0;
      end else begin
        if (c != 0) begin
          if (c >= limit) c = {1'b0, delay_q};
          else rep[b] = 1'b0;
        end
        c = c + 1'b1;
      end
      hold_cnt[pl][b] = c;
    end
    last_held[pl] = held;
    r.player = pl;
    r.held   = held;
    r.rep    = rep;
    r.edges  = held & ~prev;
  endtask

  always @(posedge clk) begin
    frame_result_t want;
    frame_result_t next_due;
    if (!rst_n) begin
      delay_q  = DELAY_RST;
      period_q = PERIOD_RST;
      thresh_q = THRESH_RST;
      for (int p = 0; p < NUM_PLAYERS; p++) begin
        last_held[p] = '0;
        for (int b = 0; b < LANES; b++) hold_cnt[p][b] = '0;
      end
      due_results.delete();
      err_count    = 0;
      result_total = 0;
      pulse_total  = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_DELAY:  delay_q  = cfg_data[DELAY_W-1:0];
          CFG_PERIOD: period_q = cfg_data[DELAY_W-1:0];
          CFG_THRESH: thresh_q = cfg_data[THR_W-1:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (due_results.size() == 0) begin
          report("unexpected result", out_held_buttons, '0);
        end else begin
          want = due_results.pop_front();
          if (out_player !== want.player)
            report("player", {14'd0, out_player}, {14'd0, want.player});
          if (out_held_buttons !== want.held)
            report("held_buttons", out_held_buttons, want.held);
          if (out_repeat_buttons !== want.rep)
            report("repeat_buttons", out_repeat_buttons, want.rep);
          if (out_pressed_edges !== want.edges)
            report("pressed_edges", out_pressed_edges, want.edges);
          result_total++;
          pulse_total += $countones(want.rep);
        end
      end
      if (in_valid && in_ready) begin
        fold_and_repeat(in_player, in_buttons, in_left_x, in_left_y, next_due);
        due_results.push_back(next_due);
      end
    end
    mismatches   <= err_count;
    due_count    <= due_results.size();
    results_seen <= result_total;
    pulses_seen  <= pulse_total;
  end

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Gamepad auto-repeat testbench
// Directed frames at the stick and button extremes, then held-button
// sequences with random content across several register settings and
// sender/receiver idle mixes, checked frame by frame by the checker.
// ---------------------------------------------------------------------------
module tb;
  import gpar_pkg::*;

  localparam logic [1:0] CFG_SPARE = 2'd3;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic [PL_W-1:0]    in_player;
  logic [LANES-1:0]   in_buttons;
  logic [STICK_W-1:0] in_left_x;
  logic [STICK_W-1:0] in_left_y;
  logic               out_valid;
  logic               out_ready;
  logic [PL_W-1:0]    out_player;
  logic [LANES-1:0]   out_held_buttons;
  logic [LANES-1:0]   out_repeat_buttons;
  logic [LANES-1:0]   out_pressed_edges;
  logic               cfg_we;
  logic [1:0]         cfg_index;
  logic [CFG_W-1:0]   cfg_data;

  int mismatches;
  int due_count;
  int results_seen;
  int pulses_seen;

  int idle_pct;
  int stall_pct;
  int hold_left;
  int frames_sent;
  int settings_used;
  int cur_delay;
  int cur_period;
  int cur_thresh;
  int seg_budget;
  int seg_start;
  int hold_cap;
  bit pressure_done;

  gamepad_autorepeat dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_player          (in_player),
    .in_buttons         (in_buttons),
    .in_left_x          (in_left_x),
    .in_left_y          (in_left_y),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_player         (out_player),
    .out_held_buttons   (out_held_buttons),
    .out_repeat_buttons (out_repeat_buttons),
    .out_pressed_edges  (out_pressed_edges),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  gamepad_repeat_checker checker_i (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_player          (in_player),
    .in_buttons         (in_buttons),
    .in_left_x          (in_left_x),
    .in_left_y          (in_left_y),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_player         (out_player),
    .out_held_buttons   (out_held_buttons),
    .out_repeat_buttons (out_repeat_buttons),
    .out_pressed_edges  (out_pressed_edges),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .mismatches         (mismatches),
    .due_count          (due_count),
    .results_seen       (results_seen),
    .pulses_seen        (pulses_seen)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("FAIL gamepad_autorepeat");
    $finish;
  end

  // receiver: random stalls, or a counted hold-off
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  function automatic logic [STICK_W-1:0] pick_stick(input int t);
    int v;
    case ($urandom_range(9))
      0: v = 0;
      1: v = t;
      2: v = -t;
      3: v = t - 1;
      4: v = 1 - t;
      5: v = 32767;
      6: v = -32768;
      default: v = $urandom;
    endcase
    return v[STICK_W-1:0];
  endfunction

  task automatic send_frame(input logic [PL_W-1:0] pl, input logic [LANES-1:0] btn,
                            input logic [STICK_W-1:0] x, input logic [STICK_W-1:0] y);
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    in_player  <= pl;
    in_buttons <= btn;
    in_left_x  <= x;
    in_left_y  <= y;
    do @(posedge clk); while (!in_ready);
    frames_sent++;
  endtask

  // drop valid and wait until every transfer has its result
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    do @(posedge clk); while (due_count != 0);
  endtask

  task automatic set_config(input int d, input int p, input int t, input bit spare);
    logic [6:0] junk;
    junk = 7'($urandom);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_DELAY;
    cfg_data  <= {junk, d[7:0]};
    @(negedge clk);
    junk = 7'($urandom);
    cfg_index <= CFG_PERIOD;
    cfg_data  <= {junk, p[7:0]};
    @(negedge clk);
    cfg_index <= CFG_THRESH;
    cfg_data  <= t[14:0];
    if (spare) begin
      @(negedge clk);
      cfg_index <= CFG_SPARE;
      cfg_data  <= CFG_W'($urandom);
    end
    @(negedge clk);
    cfg_we <= 1'b0;
    cur_delay  = d;
    cur_period = p;
    cur_thresh = t;
    settings_used++;
  endtask

  task automatic play_hold(input int cap);
    logic [PL_W-1:0]    pl;
    logic [PL_W-1:0]    other;
    logic [LANES-1:0]   base;
    logic [STICK_W-1:0] sx;
    logic [STICK_W-1:0] sy;
    logic [3:0]         flip;
    int                 n;
    pl = PL_W'($urandom_range(3));
    base = LANES'($urandom & $urandom);
    if ($urandom_range(3) == 0) base = LANES'($urandom);
    sx = pick_stick(cur_thresh);
    sy = pick_stick(cur_thresh);
    n = $urandom_range(cap, 2);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < 20) begin
        other = pl ^ PL_W'($urandom_range(3, 1));
        send_frame(other, LANES'($urandom), STICK_W'($urandom), STICK_W'($urandom));
      end
      if ($urandom_range(99) < 6) begin
        flip = 4'($urandom_range(15));
        base[flip] = ~base[flip];
      end
      if ($urandom_range(99) < 4) begin
        send_frame(pl, '0, '0, '0);
      end
      if ($urandom_range(99) < 25) sx = pick_stick(cur_thresh);
      send_frame(pl, base, sx, sy);
    end
  endtask

  initial begin
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_player  = '0;
    in_buttons = '0;
    in_left_x  = '0;
    in_left_y  = '0;
    out_ready  = 1'b0;
    cfg_we     = 1'b0;
    cfg_index  = CFG_DELAY;
    cfg_data   = '0;
    idle_pct   = 0;
    stall_pct  = 0;
    hold_left  = 0;
    frames_sent   = 0;
    settings_used = 1;
    cur_delay     = int'(DELAY_RST);
    cur_period    = int'(PERIOD_RST);
    cur_thresh    = int'(THRESH_RST);
    pressure_done = 1'b0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    // extremes under the reset settings; second pulse on the next held frame
    send_frame(2'd0, 16'h0000, 16'h0000, 16'h0000);
    send_frame(2'd1, 16'hffff, 16'h7fff, 16'h7fff);
    send_frame(2'd1, 16'hffff, 16'h7fff, 16'h7fff);
    send_frame(2'd1, 16'hffff, 16'h7fff, 16'h7fff);
    send_frame(2'd2, 16'h0000, 16'h4000, 16'h4000);
    send_frame(2'd2, 16'h0000, 16'h3fff, 16'h3fff);
    send_frame(2'd3, 16'h0000, 16'hc000, 16'hc000);
    send_frame(2'd3, 16'h0000, 16'hc001, 16'hc001);
    send_frame(2'd0, 16'h0000, 16'h8000, 16'h8000);
    send_frame(2'd0, 16'h5a5a, 16'h0000, 16'h0000);
    send_frame(2'd1, 16'h0000, 16'h0000, 16'h0000);

    // zero delay and period, plus a write to an index past the list
    settle();
    set_config(0, 0, 16384, 1'b1);
    repeat (4) send_frame(2'd2, 16'h0081, 16'h0000, 16'h0000);

    // settings changed in the middle of a hold
    settle();
    set_config(2, 2, 16384, 1'b0);
    repeat (7) send_frame(2'd3, 16'h8001, 16'h0000, 16'h0000);
    settle();
    set_config(1, 1, 16384, 1'b0);
    repeat (2) send_frame(2'd3, 16'h8001, 16'h0000, 16'h0000);

    for (int seg = 0; seg < 8; seg++) begin
      settle();
      case (seg)
        0: set_config($urandom_range(6, 1), $urandom_range(4, 1), $urandom_range(32767), 1'b0);
        1: set_config(1, 1, 0, 1'b0);
        2: set_config(255, 255, 32767, 1'b0);
        3: set_config($urandom_range(8, 1), $urandom_range(3), 16384, 1'b0);
        4: set_config(0, 0, $urandom_range(32767), 1'b0);
        5: set_config($urandom_range(10, 1), $urandom_range(6, 1), $urandom_range(32767), 1'b1);
        6: set_config(255, 1, 1, 1'b0);
        default: set_config(2, 255, $urandom_range(32767), 1'b0);
      endcase
      case (seg / 2)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 69; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 69; end
        default: begin idle_pct = 35; stall_pct = 35; end
      endcase
      hold_cap = cur_delay + 2 * cur_period + 4;
      if (hold_cap > 40) hold_cap = 40;
      seg_start  = frames_sent;
      seg_budget = frames_sent + 60;
      while (frames_sent < seg_budget) begin
        if ($urandom_range(99) < 20)
          send_frame(PL_W'($urandom_range(3)), LANES'($urandom),
                     STICK_W'($urandom), STICK_W'($urandom));
        else
          play_hold(hold_cap);
        if (!pressure_done && frames_sent > seg_start + 4) begin
          hold_left = 300;
          pressure_done = 1'b1;
        end
      end
    end

    settle();
    repeat (8) @(posedge clk);
    $display("covered %0d frames and %0d results with %0d repeat bits over %0d settings",
             frames_sent, results_seen, pulses_seen, settings_used);
    $display("idle mixes: none, sender, receiver, both, plus a 300-cycle receiver hold-off");
    if (mismatches == 0) begin
      $display("PASS gamepad_autorepeat");
    end else begin
      $display("FAIL gamepad_autorepeat");
    end
    $finish;
  end

endmodule
